// File: rtl/assert_macros.svh
// Assertion macros shared by the velocity stencil RTL.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define CHECK_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/evs_pkg.sv
// Shared types and constants for the elastic velocity stencil.
// No dependencies; imported by every module of the block except evs_ram.
package evs_pkg;

  localparam int DATA_W   = 32;
  localparam int FIELDS   = 6;
  localparam int ROWS     = 8;
  localparam int TAPS     = 4;
  localparam int STENCILS = 4;
  localparam int COL_W    = 10;
  localparam int ROW_W    = 16;
  localparam int GW_W     = 11;
  localparam int HALO     = 4;

  // Field slots inside one memory word and one input beat
  localparam int F_SX  = 0;
  localparam int F_SZ  = 1;
  localparam int F_SXZ = 2;
  localparam int F_B   = 3;
  localparam int F_VX  = 4;
  localparam int F_VZ  = 5;

  // Stencil slots
  localparam int S_SX_DX  = 0;
  localparam int S_SXZ_DZ = 1;
  localparam int S_SXZ_DX = 2;
  localparam int S_SZ_DZ  = 3;

  // Configuration register indexes
  localparam logic [2:0] REG_COEF_FIRST  = 3'd0;
  localparam logic [2:0] REG_COEF_SECOND = 3'd1;
  localparam logic [2:0] REG_COEF_THIRD  = 3'd2;
  localparam logic [2:0] REG_COEF_FOURTH = 3'd3;
  localparam logic [2:0] REG_GRID_WIDTH  = 3'd4;
  localparam logic [2:0] REG_GRID_HEIGHT = 3'd5;

  typedef logic signed [DATA_W-1:0] sword_t;
  typedef logic [DATA_W:0] diff_t;
  typedef sword_t [FIELDS-1:0] item_t;
  // One column of the line store: every field over the last eight rows, age 0 newest
  typedef logic [FIELDS-1:0][ROWS-1:0][DATA_W-1:0] word_t;

  typedef struct packed {
    diff_t [STENCILS-1:0][TAPS-1:0] diff;
    sword_t                         b;
    sword_t [1:0]                   v_old;
    logic [COL_W-1:0]               column;
    logic [ROW_W-1:0]               row;
  } taps_t;

  typedef struct packed {
    sword_t           b;
    sword_t [1:0]     v_old;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
  } meta_t;

  // Difference of two 32-bit samples at 33 bits, no overflow
  function automatic diff_t sub_ext(input logic [DATA_W-1:0] p, input logic [DATA_W-1:0] m);
    return {p[DATA_W-1], p} - {m[DATA_W-1], m};
  endfunction

endpackage

// File: rtl/evs_ram.sv
// Generic simple dual-port RAM: one write port, two registered read ports.
// No dependencies.
module evs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: rtl/evs_window.sv
// Line store and stencil window: reads, shifts and writes back one column per beat.
// Depends on evs_pkg, evs_ram and assert_macros.svh.
`include "assert_macros.svh"
module evs_window import evs_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  item_t            in_item,
  input  logic [AW-1:0]    in_col,
  input  logic             in_emit,
  input  logic [COL_W-1:0] in_column,
  input  logic [ROW_W-1:0] in_row,
  output logic             out_valid,
  input  logic             out_ready,
  output taps_t            taps
);

  logic             accept;
  logic             s1_v;
  logic             s1_adv;
  logic             s1_emit;
  logic [AW-1:0]    s1_col;
  item_t            s1_item;
  logic [COL_W-1:0] s1_column;
  logic [ROW_W-1:0] s1_row;
  logic             t_v;
  logic             t_take;
  word_t            rd_a;
  word_t            rd_b;
  word_t            wr_word;
  logic [AW-1:0]    ahead_addr;
  sword_t [TAPS-1:0] hist_sx;
  sword_t [TAPS-1:0] hist_sxz;
  sword_t [TAPS-1:0] ahd_sx;
  sword_t [TAPS-1:0] ahd_sxz;
  sword_t [2*TAPS:0] win_sx;
  sword_t [2*TAPS:0] win_sxz;
  taps_t            taps_next;
  logic [DATA_W-1:0] sz_far;

  assign accept     = in_valid && in_ready;
  assign t_take     = t_v && out_ready;
  assign s1_adv     = s1_v && (!s1_emit || !t_v || t_take);
  assign in_ready   = !s1_v || s1_adv;
  assign ahead_addr = in_col + AW'(HALO);
  assign out_valid  = t_v;

  // Column store: read the column and the one four ahead, write the shifted column back
  evs_ram #(
    .WIDTH ($bits(word_t)),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk     (clk),
    .we      (s1_adv),
    .waddr   (s1_col),
    .wdata   (wr_word),
    .re      (accept),
    .raddr_a (in_col),
    .raddr_b (ahead_addr),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // Push the new row into the column, drop the oldest
  always_comb begin
    for (int f = 0; f < FIELDS; f++) begin
      wr_word[f][0] = s1_item[f];
      for (int a = 1; a < ROWS; a++) begin
        wr_word[f][a] = rd_a[f][a-1];
      end
    end
  end

  // Hold the beat whose column is being read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (accept) begin
      s1_v <= 1'b1;
    end else if (s1_adv) begin
      s1_v <= 1'b0;
    end
    if (accept) begin
      s1_emit   <= in_emit;
      s1_col    <= in_col;
      s1_item   <= in_item;
      s1_column <= in_column;
      s1_row    <= in_row;
    end
  end

  // Advance the horizontal windows of the centre row
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      hist_sx  <= {sword_t'(rd_a[F_SX][HALO-1]), hist_sx[TAPS-1:1]};
      hist_sxz <= {sword_t'(rd_a[F_SXZ][HALO-1]), hist_sxz[TAPS-1:1]};
      ahd_sx   <= {sword_t'(rd_b[F_SX][HALO-1]), ahd_sx[TAPS-1:1]};
      ahd_sxz  <= {sword_t'(rd_b[F_SXZ][HALO-1]), ahd_sxz[TAPS-1:1]};
    end
  end

  // Window entry i holds column x-4+i of the centre row
  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      win_sx[i]         = hist_sx[i];
      win_sxz[i]        = hist_sxz[i];
      win_sx[i+TAPS]    = ahd_sx[i];
      win_sxz[i+TAPS]   = ahd_sxz[i];
    end
    win_sx[2*TAPS]  = rd_b[F_SX][HALO-1];
    win_sxz[2*TAPS] = rd_b[F_SXZ][HALO-1];
  end

  // Form the difference pairs; age a in the column is row r-1-a
  always_comb begin
    sz_far = '0;
    for (int j = 0; j < TAPS; j++) begin
      taps_next.diff[S_SX_DX][j]  = sub_ext(win_sx[j+4], win_sx[3-j]);
      taps_next.diff[S_SXZ_DZ][j] = sub_ext(rd_a[F_SXZ][3-j], rd_a[F_SXZ][4+j]);
      taps_next.diff[S_SXZ_DX][j] = sub_ext(win_sxz[5+j], win_sxz[4-j]);
    end
    for (int j = 0; j < TAPS - 1; j++) begin
      taps_next.diff[S_SZ_DZ][j] = sub_ext(rd_a[F_SZ][2-j], rd_a[F_SZ][3+j]);
    end
    sz_far = s1_item[F_SZ];
    taps_next.diff[S_SZ_DZ][TAPS-1] = sub_ext(sz_far, rd_a[F_SZ][ROWS-2]);
    taps_next.b        = rd_a[F_B][HALO-1];
    taps_next.v_old[0] = rd_a[F_VX][HALO-1];
    taps_next.v_old[1] = rd_a[F_VZ][HALO-1];
    taps_next.column   = s1_column;
    taps_next.row      = s1_row;
  end

  // Hold the taps until the arithmetic takes them
  always_ff @(posedge clk) begin
    if (rst) begin
      t_v <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      t_v <= 1'b1;
    end else if (t_take) begin
      t_v <= 1'b0;
    end
    if (s1_adv && s1_emit) begin
      taps <= taps_next;
    end
  end

  `CHECK_IMPLY(a_no_rw_clash, accept && s1_adv, (in_col != s1_col) && (ahead_addr != s1_col), "line store read and write hit the same column")
  `CHECK_NEXT(a_taps_loaded, s1_adv && s1_emit, t_v, "interior point lost before the arithmetic")
  `CHECK_IMPLY(a_accept_room, accept, !s1_v || s1_adv, "beat accepted over a pending column read")

endmodule

// File: rtl/evs_datapath.sv
// Fixed-point arithmetic: stencil products, sums, buoyancy product and saturation.
// Depends on evs_pkg and assert_macros.svh.
`include "assert_macros.svh"
module evs_datapath import evs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  sword_t [TAPS-1:0]            coef,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  taps_t                        taps,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0][DATA_W-1:0]       vel_new,
  output logic [COL_W-1:0]             column,
  output logic [ROW_W-1:0]             row
);

  localparam int NST   = 6;
  localparam int MUL_W = 2 * DATA_W + 1;
  localparam int ACC_W = MUL_W + 2;
  localparam int SW    = ACC_W - FRAC_BITS;
  localparam int SUM_W = SW + 1;
  localparam int LO_W  = SUM_W / 2;
  localparam int HI_W  = SUM_W - LO_W;
  localparam int PW    = DATA_W + SUM_W;
  localparam int TW    = PW + 1;

  logic [NST-1:0] v;
  logic [NST-1:0] en;

  logic signed [STENCILS-1:0][TAPS-1:0][MUL_W-1:0] prod;
  logic signed [STENCILS-1:0][SW-1:0]              st;
  logic signed [1:0][SUM_W-1:0]                    sum;
  logic signed [1:0][DATA_W+LO_W:0]                p_lo;
  logic signed [1:0][DATA_W+HI_W-1:0]              p_hi;
  logic signed [1:0][PW-1:0]                       full;
  meta_t [NST-1:0]                                 meta;

  logic signed [ACC_W-1:0]         acc [STENCILS];
  logic signed [ACC_W-1:0]         acc_sh [STENCILS];
  logic signed [PW-1:0]            full_sh [2];
  logic signed [TW-1:0]            upd [2];
  logic [1:0][DATA_W-1:0]          sat;
  meta_t                           meta_in;

  // Stage enables: a stage loads when empty or when the next one loads
  always_comb begin
    en[NST-1] = !v[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign meta_in.b      = taps.b;
  assign meta_in.v_old  = taps.v_old;
  assign meta_in.column = taps.column;
  assign meta_in.row    = taps.row;

  // Carry the point's own values alongside the arithmetic
  always_ff @(posedge clk) begin
    if (en[0]) begin
      meta[0] <= meta_in;
    end
    for (int k = 1; k < NST; k++) begin
      if (en[k]) begin
        meta[k] <= meta[k-1];
      end
    end
  end

  // Stage 0: one product per coefficient and pair
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int s = 0; s < STENCILS; s++) begin
        for (int k = 0; k < TAPS; k++) begin
          prod[s][k] <= $signed(coef[k]) * $signed(taps.diff[s][k]);
        end
      end
    end
  end

  // Stage 1: full-width stencil sums, then shift out the fraction
  always_comb begin
    for (int s = 0; s < STENCILS; s++) begin
      acc[s] = ACC_W'($signed(prod[s][0])) + ACC_W'($signed(prod[s][1]))
             + ACC_W'($signed(prod[s][2])) + ACC_W'($signed(prod[s][3]));
      acc_sh[s] = acc[s] >>> FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int s = 0; s < STENCILS; s++) begin
        st[s] <= acc_sh[s][SW-1:0];
      end
    end
  end

  // Stage 2: pair the stencils per velocity component
  always_ff @(posedge clk) begin
    if (en[2]) begin
      sum[0] <= SUM_W'($signed(st[S_SX_DX]))  + SUM_W'($signed(st[S_SXZ_DZ]));
      sum[1] <= SUM_W'($signed(st[S_SXZ_DX])) + SUM_W'($signed(st[S_SZ_DZ]));
    end
  end

  // Stage 3: buoyancy times the low and high halves of each sum
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int c = 0; c < 2; c++) begin
        p_lo[c] <= $signed(meta[2].b) * $signed({1'b0, sum[c][LO_W-1:0]});
        p_hi[c] <= $signed(meta[2].b) * $signed(sum[c][SUM_W-1:LO_W]);
      end
    end
  end

  // Stage 4: recombine the partial products
  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int c = 0; c < 2; c++) begin
        full[c] <= (PW'($signed(p_hi[c])) <<< LO_W) + PW'($signed(p_lo[c]));
      end
    end
  end

  // Stage 5: shift, add the old velocity, saturate to 32 bits
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      full_sh[c] = $signed(full[c]) >>> FRAC_BITS;
      upd[c]     = TW'($signed(full_sh[c])) + TW'($signed(meta[4].v_old[c]));
      if ((&upd[c][TW-1:DATA_W-1]) || !(|upd[c][TW-1:DATA_W-1])) begin
        sat[c] = upd[c][DATA_W-1:0];
      end else if (upd[c][TW-1]) begin
        sat[c] = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        sat[c] = {1'b0, {(DATA_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      vel_new <= sat;
    end
  end

  assign column = meta[NST-1].column;
  assign row    = meta[NST-1].row;

  `CHECK_IMPLY(a_stall_from_output, !in_ready, out_valid && !out_ready, "input stalled while the output can move")
  `CHECK_NEXT(a_output_held, out_valid && !out_ready, out_valid, "result dropped while the receiver stalled")
  `CHECK_IMPLY(a_chain_full, !in_ready, &v, "input stalled with a bubble in the pipeline")

endmodule

// File: rtl/elastic_velocity_stencil.sv
// Top level of the elastic velocity stencil: configuration, raster counters and the
// column store feeding the fixed-point pipeline. Depends on evs_pkg, evs_window, evs_datapath.
//
// Usage: grid points enter on the s_axis channel in raster order, x fastest, one point
// per beat. When point (x, z+4) is accepted, interior point (x, z) is updated, for
// 4 <= x < width-4 and 4 <= z < height-4, and its new vx and vz leave on m_axis with
// the point's column and row. Border points give no output beat.
// Throughput: one point per clock while the receiver keeps up; the line store is one RAM whose column is
// read, shifted by a row and written back when the beat leaves the read stage, with a second read
// port four columns ahead for the horizontal window.
// The result beat for a window passes the RAM read at the accepting edge, 1 tap stage and
// 6 arithmetic stages ending in the output register.
// Reset clears the counters and the configuration (coefficients 0, grid 1024 x 1024);
// the line store keeps no reset and fills as rows stream in, so a new frame gives
// nothing until its ninth row. Configuration must be written through cfg_we/cfg_index/
// cfg_data while the block is idle; the block itself does not enforce this.
// When the receiver stalls, the pipeline fills its bubbles and then deasserts
// s_axis_tready; no beat is lost or repeated.
module elastic_velocity_stencil import evs_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // stress_xx, stress_zz, stress_xz, buoyancy, vel_x_old, vel_z_old
  input  logic [191:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // vel_x_new, vel_z_new, column, row, 6 zero bits
  output logic [95:0]   m_axis_tdata,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = 17;

  sword_t [TAPS-1:0]  coef;
  logic [GW_W-1:0]    grid_width;
  logic [ROW_W-1:0]   grid_height;
  logic [AW-1:0]      col_count;
  logic [ROW_W-1:0]   row_count;
  logic [CW-1:0]      width_eff;
  logic [CW-1:0]      height_eff;
  logic [CW-1:0]      col_ext;
  logic [CW-1:0]      row_ext;
  logic               accept;
  logic               emit;
  logic               t_valid;
  logic               t_ready;
  taps_t              taps;
  logic [1:0][DATA_W-1:0] vel_new;
  logic [COL_W-1:0]   column;
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   centre_col;
  logic [ROW_W-1:0]   centre_row;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      coef        <= '0;
      grid_width  <= GW_W'(1024);
      grid_height <= ROW_W'(1024);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COEF_FIRST:  coef[0]     <= cfg_data;
        REG_COEF_SECOND: coef[1]     <= cfg_data;
        REG_COEF_THIRD:  coef[2]     <= cfg_data;
        REG_COEF_FOURTH: coef[3]     <= cfg_data;
        REG_GRID_WIDTH:  grid_width  <= cfg_data[GW_W-1:0];
        REG_GRID_HEIGHT: grid_height <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the grid size to what the line store supports
  always_comb begin
    width_eff = CW'(grid_width);
    if (width_eff < CW'(2 * HALO + 1)) begin
      width_eff = CW'(2 * HALO + 1);
    end else if (width_eff > CW'(MAX_WIDTH)) begin
      width_eff = CW'(MAX_WIDTH);
    end
    height_eff = CW'(grid_height);
    if (height_eff < CW'(2 * HALO + 1)) begin
      height_eff = CW'(2 * HALO + 1);
    end
  end

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign col_ext = CW'(col_count);
  assign row_ext = CW'(row_count);

  // Interior point whose window closes with this beat
  assign emit = (row_ext >= CW'(2 * HALO)) && (row_ext < height_eff)
             && (col_ext >= CW'(HALO)) && (col_ext + CW'(HALO) < width_eff);
  assign centre_col = COL_W'(col_count);
  assign centre_row = row_count - ROW_W'(HALO);

  // Raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (col_ext + CW'(1) >= width_eff) begin
        col_count <= '0;
        if (row_ext + CW'(1) >= height_eff) begin
          row_count <= '0;
        end else begin
          row_count <= row_count + ROW_W'(1);
        end
      end else begin
        col_count <= col_count + AW'(1);
      end
    end
  end

  evs_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (s_axis_tdata),
    .in_col    (col_count),
    .in_emit   (emit),
    .in_column (centre_col),
    .in_row    (centre_row),
    .out_valid (t_valid),
    .out_ready (t_ready),
    .taps      (taps)
  );

  evs_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .coef      (coef),
    .in_valid  (t_valid),
    .in_ready  (t_ready),
    .taps      (taps),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .vel_new   (vel_new),
    .column    (column),
    .row       (row)
  );

  assign m_axis_tdata = {6'd0, row, column, vel_new[1], vel_new[0]};

endmodule

// File: dv/evs_checker.sv
// Checker for the elastic velocity stencil: mirrors configuration writes,
// predicts each updated point from the input beats, compares output beats.
// Depends on evs_pkg for register indexes.
module evs_checker import evs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [95:0]  m_axis_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           err_count,
  output int           pending
);

  typedef struct packed {
    logic [31:0] vx;
    logic [31:0] vz;
    logic [9:0]  column;
    logic [15:0] row;
  } velocity_t;

  typedef logic signed [127:0] acc_t;

  velocity_t   velocity_q[$];
  logic signed [31:0] coef[4];
  logic [10:0] gw;
  logic [15:0] gh;
  logic [31:0] sx_buf[9][1024];
  logic [31:0] sz_buf[9][1024];
  logic [31:0] sxz_buf[9][1024];
  logic [31:0] b_buf[9][1024];
  logic [31:0] vx_buf[9][1024];
  logic [31:0] vz_buf[9][1024];
  int unsigned col_n;
  int unsigned row_n;

  assign pending = velocity_q.size();

  // Weighted sum of four difference pairs at full width, then shift down
  function automatic acc_t diff_sum(input logic [3:0][31:0] p, input logic [3:0][31:0] m);
    acc_t acc;
    acc = 0;
    for (int k = 0; k < 4; k++)
      acc += acc_t'(coef[k]) * (acc_t'($signed(p[k])) - acc_t'($signed(m[k])));
    return acc >>> 16;
  endfunction

  function automatic logic [31:0] new_velocity(input logic [31:0] old, input logic [31:0] b,
                                              input acc_t s1, input acc_t s2);
    acc_t t;
    t = ((acc_t'($signed(b)) * (s1 + s2)) >>> 16) + acc_t'($signed(old));
    if (t > acc_t'(32'sh7fffffff)) return 32'h7fffffff;
    if (t < -acc_t'(64'sh80000000)) return 32'h80000000;
    return t[31:0];
  endfunction

  // Store one point and predict the interior point it completes
  task automatic take_point(input logic [191:0] d);
    int unsigned w, h, x, r, slot, z, zc;
    logic [3:0][31:0] pa, ma, pb, mb;
    acc_t s1, s2, s3, s4;
    velocity_t e;
    w = gw; h = gh;
    if (w < 9) w = 9;
    if (w > 1024) w = 1024;
    if (h < 9) h = 9;
    x = col_n % 1024; r = row_n; slot = r % 9;
    sx_buf[slot][x] = d[31:0];
    sz_buf[slot][x] = d[63:32];
    sxz_buf[slot][x] = d[95:64];
    b_buf[slot][x] = d[127:96];
    vx_buf[slot][x] = d[159:128];
    vz_buf[slot][x] = d[191:160];
    if (r >= 8 && r < h && x >= 4 && x + 4 < w) begin
      z = r - 4; zc = z % 9;
      for (int k = 1; k <= 4; k++) begin
        pa[k-1] = sx_buf[zc][x+k-1];
        ma[k-1] = sx_buf[zc][x-k];
        pb[k-1] = sxz_buf[(z+k-1) % 9][x];
        mb[k-1] = sxz_buf[(z-k) % 9][x];
      end
      s1 = diff_sum(pa, ma);
      s2 = diff_sum(pb, mb);
      for (int k = 1; k <= 4; k++) begin
        pa[k-1] = sxz_buf[zc][x+k];
        ma[k-1] = sxz_buf[zc][x+1-k];
        pb[k-1] = sz_buf[(z+k) % 9][x];
        mb[k-1] = sz_buf[(z+1-k) % 9][x];
      end
      s3 = diff_sum(pa, ma);
      s4 = diff_sum(pb, mb);
      e.vx = new_velocity(vx_buf[zc][x], b_buf[zc][x], s1, s2);
      e.vz = new_velocity(vz_buf[zc][x], b_buf[zc][x], s3, s4);
      e.column = x[9:0];
      e.row = z[15:0];
      velocity_q.push_back(e);
    end
    if (col_n + 1 >= w) begin
      col_n = 0;
      row_n = (row_n + 1 >= h) ? 0 : row_n + 1;
    end else begin
      col_n = col_n + 1;
    end
  endtask

  // Mirror configuration, predict on input beats, compare output beats
  always @(posedge clk) begin
    velocity_t e;
    if (rst) begin
      for (int k = 0; k < 4; k++) coef[k] = 0;
      gw = 11'd1024; gh = 16'd1024;
      col_n = 0; row_n = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_COEF_FIRST:  coef[0] = cfg_data;
          REG_COEF_SECOND: coef[1] = cfg_data;
          REG_COEF_THIRD:  coef[2] = cfg_data;
          REG_COEF_FOURTH: coef[3] = cfg_data;
          REG_GRID_WIDTH:  gw = cfg_data[10:0];
          REG_GRID_HEIGHT: gh = cfg_data[15:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (velocity_q.size() == 0) begin
          $error("unexpected output beat %h", m_axis_tdata);
          err_count++;
        end else begin
          e = velocity_q.pop_front();
          if (m_axis_tdata[31:0] !== e.vx) begin
            $error("vel_x_new: expected %h, got %h", e.vx, m_axis_tdata[31:0]);
            err_count++;
          end
          if (m_axis_tdata[63:32] !== e.vz) begin
            $error("vel_z_new: expected %h, got %h", e.vz, m_axis_tdata[63:32]);
            err_count++;
          end
          if (m_axis_tdata[73:64] !== e.column) begin
            $error("column: expected %0d, got %0d", e.column, m_axis_tdata[73:64]);
            err_count++;
          end
          if (m_axis_tdata[89:74] !== e.row) begin
            $error("row: expected %0d, got %0d", e.row, m_axis_tdata[89:74]);
            err_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) take_point(s_axis_tdata);
    end
  end

  initial err_count = 0;

endmodule

// File: dv/tb_top.sv
// Testbench top for the elastic velocity stencil: clock, reset, grid frames
// with bursty input and a stalling receiver, and the verdict. Uses evs_checker.
module tb_top;
  import evs_pkg::*;

  localparam int IDLE_LIMIT = 5000;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [95:0]  m_axis_tdata;
  logic         cfg_we = 0;
  logic [2:0]   cfg_index = REG_COEF_FIRST;
  logic [31:0]  cfg_data = '0;

  int  err_count, pending, idle_cycles;
  int  burst_left;
  bit  no_gaps, hold_req;

  always #5 clk = ~clk;

  elastic_velocity_stencil u_top (.*);

  evs_checker u_chk (.*);

  // Receiver: randomly changing stall pattern, plus one long hold-off
  initial begin
    int mode;
    mode = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_axis_tready <= 0;
        repeat (400) @(negedge clk);
        hold_req = 0;
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: m_axis_tready <= 1;
        1: m_axis_tready <= ($urandom_range(0, 9) < 7);
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ($urandom_range(0, 9) < 9);
      endcase
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("elastic_velocity_stencil: mismatch");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // Offer one point, holding it until accepted; random gaps between bursts unless no_gaps is set
  task automatic send_point(input logic [191:0] d);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if (!no_gaps && $urandom_range(0, 2) != 0) begin
        s_axis_tvalid <= 0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1;
    s_axis_tdata <= d;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h3ffff) - 32'h20000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [191:0] rand_point();
    logic [191:0] d;
    for (int f = 0; f < 6; f++) d[f*32 +: 32] = rand_word();
    return d;
  endfunction

  // Drain the pipeline and let it settle before a configuration change
  task automatic settle();
    s_axis_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_coefs(input bit rough);
    for (int k = 0; k < 4; k++)
      write_reg(3'(REG_COEF_FIRST + 3'(k)), rough ? rand_word()
                                                  : $urandom_range(0, 32'h1ffff) - 32'h10000);
  endtask

  task automatic run_frames(input int n, input int w, input int h);
    for (int i = 0; i < n * w * h; i++) send_point(rand_point());
  endtask

  initial begin
    logic [191:0] d;
    burst_left = 0; no_gaps = 0; hold_req = 0;
    repeat (5) @(negedge clk);
    rst <= 0;

    // Smallest grid, extreme coefficients and alternating extreme stresses
    write_reg(REG_COEF_FIRST, 32'h7fffffff);
    write_reg(REG_COEF_SECOND, 32'h80000000);
    write_reg(REG_COEF_THIRD, 32'h7fffffff);
    write_reg(REG_COEF_FOURTH, 32'h80000000);
    write_reg(REG_GRID_WIDTH, 9);
    write_reg(REG_GRID_HEIGHT, 9);
    for (int i = 0; i < 81; i++) begin
      for (int f = 0; f < 6; f++)
        d[f*32 +: 32] = ((i + f) % 2) ? 32'h7fffffff : 32'h80000000;
      send_point(d);
    end
    settle();

    // Undersized grid clamps to nine by nine
    set_coefs(0);
    write_reg(REG_GRID_WIDTH, 3);
    write_reg(REG_GRID_HEIGHT, 2);
    run_frames(1, 9, 9);
    settle();

    // Small grid, gentle coefficients with no input gaps, then rough coefficients
    write_reg(REG_GRID_WIDTH, 12);
    write_reg(REG_GRID_HEIGHT, 10);
    no_gaps = 1;
    run_frames(1, 12, 10);
    no_gaps = 0;
    settle();
    set_coefs(1);
    run_frames(1, 12, 10);
    settle();

    // Tallest grid, narrow rows; long receiver hold-off part way through
    set_coefs(0);
    write_reg(REG_GRID_WIDTH, 10);
    write_reg(REG_GRID_HEIGHT, 16'hffff);
    for (int i = 0; i < 160; i++) begin
      if (i == 85) hold_req = 1;
      send_point(rand_point());
    end
    s_axis_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    if (err_count == 0 && pending == 0)
      $display("elastic_velocity_stencil: match");
    else
      $display("elastic_velocity_stencil: mismatch");
    $finish;
  end

endmodule
